[rtl/core/xcj_pkg.sv]
// Shared types and constants for the x86 CALL/JMP address filter.
package xcj_pkg;

  localparam logic [7:0] OP_CALL = 8'hE8;
  localparam logic [7:0] OP_JMP  = 8'hE9;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] HELD_FULL = 2'd3;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // One queued group of output bytes; byte 0 goes out first.
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  cnt_m1;
    logic        last;
  } entry_t;

endpackage

[rtl/core/xcj_front.sv]
// Front end: accepts stream bytes, tracks position, collects and converts operands.
module xcj_front
  import xcj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       push_valid,
  output entry_t     push_data,
  input  logic       push_ready
);

  logic [31:0] pos_r, pos_nxt;
  logic [31:0] opc_pos_r, opc_pos_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  hb_r [3];
  mode_t       mode_r;

  logic        accept;
  logic        idle;
  logic [1:0]  held;
  logic [31:0] word;
  logic [31:0] conv;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign idle     = cnt_r inside {3'd0, [3'd5:3'd7]};
  assign held     = 2'(cnt_r - 3'd1);
  assign word     = {in_data_byte, hb_r[2], hb_r[1], hb_r[0]};
  assign conv     = (mode_r == MODE_ENCODE) ? word + opc_pos_r : word - opc_pos_r;

  always_comb begin
    pos_nxt     = pos_r;
    opc_pos_nxt = opc_pos_r;
    cnt_nxt     = cnt_r;
    push_valid  = 1'b0;
    push_data   = '{data: {24'd0, in_data_byte}, cnt_m1: 2'd0, last: in_last};
    if (accept) begin
      if (idle) begin
        push_valid = 1'b1;
        if (!in_last && (in_data_byte == OP_CALL || in_data_byte == OP_JMP)) begin
          opc_pos_nxt = pos_r;
          cnt_nxt     = 3'd1;
        end else begin
          cnt_nxt = 3'd0;
        end
      end else if (held == HELD_FULL) begin
        push_valid       = 1'b1;
        push_data.data   = conv;
        push_data.cnt_m1 = HELD_FULL;
        cnt_nxt          = 3'd0;
      end else if (in_last) begin
        push_valid       = 1'b1;
        push_data.cnt_m1 = held;
        case (held)
          2'd1:    push_data.data = {16'd0, in_data_byte, hb_r[0]};
          2'd2:    push_data.data = {8'd0, in_data_byte, hb_r[1], hb_r[0]};
          default: push_data.data = {24'd0, in_data_byte};
        endcase
        cnt_nxt = 3'd0;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
      if (in_last) begin
        pos_nxt     = '0;
        opc_pos_nxt = '0;
        cnt_nxt     = 3'd0;
      end else begin
        pos_nxt = pos_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      opc_pos_r <= '0;
      cnt_r     <= 3'd0;
      mode_r    <= MODE_ENCODE;
    end else begin
      pos_r     <= pos_nxt;
      opc_pos_r <= opc_pos_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !idle && !in_last && held != HELD_FULL) begin
      hb_r[held] <= in_data_byte;
    end
  end

endmodule

[rtl/core/xcj_queue.sv]
// Short queue of byte groups between the front end and the output sequencer.
module xcj_queue
  import xcj_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  entry_t push_data,
  output logic   push_ready,
  output logic   pop_valid,
  output entry_t pop_data,
  input  logic   pop_ready
);

  entry_t         mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           push, pop;

  assign push_ready = (count_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (QAW+1)'(1)))
    else $error("queue count did not grow on push");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r - rptr_r) == count_r[QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

[rtl/core/xcj_back.sv]
// Output sequencer: unpacks queued byte groups into a registered byte stream.
module xcj_back
  import xcj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  entry_t     pop_data,
  output logic       pop_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [31:0] sh_r;
  logic [1:0]  rem_r;
  logic        last_r;
  logic        act_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_load;
  logic        pop;

  assign out_load  = !out_valid_r || out_ready;
  assign pop_ready = !act_r || (out_load && rem_r == 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= act_r;
      end
      if (pop) begin
        act_r <= 1'b1;
      end else if (out_load && act_r && rem_r == 2'd0) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && act_r) begin
      out_byte_r <= sh_r[7:0];
      out_last_r <= last_r && (rem_r == 2'd0);
    end
    if (pop) begin
      sh_r   <= pop_data.data;
      rem_r  <= pop_data.cnt_m1;
      last_r <= pop_data.last;
    end else if (out_load && act_r) begin
      sh_r  <= {8'd0, sh_r[31:8]};
      rem_r <= rem_r - 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("output changed while stalled");

  a_no_pop_midgroup: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && rem_r != 2'd0) |-> !pop)
    else $error("group popped before previous one drained");

  a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && act_r && last_r && rem_r != 2'd0) |=> !out_last_r)
    else $error("last flag raised inside a group");

endmodule

[rtl/core/x86_call_jump_address_filter_core.sv]
// Top level of the x86 CALL/JMP address filter.
// Converts the 32-bit operand after each E8/E9 opcode byte between relative and absolute
// form (cfg_wdata 0 adds the opcode position, 1 subtracts it). One input byte is taken per
// cycle and one output byte leaves per cycle while out_ready is high; a byte passes the
// group queue, the sequencer register and the output register in turn, a converted
// operand's four bytes as one group. The sustained rate of one byte per cycle is set by
// the single-byte output port; a four-entry group queue between the converter and the
// output sequencer absorbs the four-byte bursts, and input stalls only when it is full.
module x86_call_jump_address_filter_core
  import xcj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  xcj_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  xcj_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  xcj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

[verif/x86_call_jump_address_filter_core_tb.sv]
// Self-checking testbench for the x86 CALL/JMP address filter core.
`timescale 1ns / 100ps

module x86_call_jump_address_filter_core_tb
  import xcj_pkg::*;
;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  stream_byte_t stream_q[$];
  stream_byte_t expected_bytes[$];

  // filter state mirror
  mode_t       conv_mode = MODE_ENCODE;
  logic [31:0] stream_pos = '0;
  logic [31:0] opcode_pos = '0;
  logic [2:0]  operand_cnt = '0;
  logic [7:0]  operand_held[3];

  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int stall_cycles = 0;
  int fails = 0;

  x86_call_jump_address_filter_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  always #4 clk = ~clk;

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic l);
    stream_byte_t e;
    e.data = b;
    e.last = l;
    expected_bytes.push_back(e);
  endfunction

  // Expected output bytes for one accepted input byte.
  function automatic void compute_filter_bytes(input logic [7:0] b, input logic l);
    logic [31:0] word;
    if (operand_cnt == 3'd0 || operand_cnt > 3'd4) begin
      expect_byte(b, l);
      if (!l && (b == OP_CALL || b == OP_JMP)) begin
        opcode_pos = stream_pos;
        operand_cnt = 3'd1;
      end else begin
        operand_cnt = 3'd0;
      end
    end else if (operand_cnt == 3'd4) begin
      word = {b, operand_held[2], operand_held[1], operand_held[0]};
      word = (conv_mode == MODE_ENCODE) ? word + opcode_pos : word - opcode_pos;
      expect_byte(word[7:0], 1'b0);
      expect_byte(word[15:8], 1'b0);
      expect_byte(word[23:16], 1'b0);
      expect_byte(word[31:24], l);
      operand_cnt = 3'd0;
    end else if (l) begin
      for (int i = 0; i < operand_cnt - 1; i++) expect_byte(operand_held[i], 1'b0);
      expect_byte(b, 1'b1);
      operand_cnt = 3'd0;
    end else begin
      operand_held[operand_cnt - 1] = b;
      operand_cnt = operand_cnt + 3'd1;
    end
    if (l) begin
      stream_pos = '0;
      opcode_pos = '0;
      operand_cnt = 3'd0;
    end else begin
      stream_pos = stream_pos + 32'd1;
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic l);
    stream_byte_t s;
    s.data = b;
    s.last = l;
    stream_q.push_back(s);
  endfunction

  // Opcode-dense random bytes; stream ends are rare.
  function automatic void queue_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 7);
      if (r < 2) queue_byte((r == 0) ? OP_CALL : OP_JMP, $urandom_range(0, 11) == 0);
      else queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    conv_mode = m;
    @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) compute_filter_bytes(in_data_byte, in_last);
      if (in_valid && !in_ready) begin
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (stream_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data_byte <= stream_q[0].data;
        in_last <= stream_q[0].last;
        void'(stream_q.pop_front());
        in_gap <= draw_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    stream_byte_t e;
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transfer: out_byte %0h out_last %0b", out_byte, out_last);
        fails++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte !== e.data) begin
          $error("out_byte expected %0h actual %0h", e.data, out_byte);
          fails++;
        end
        if (out_last !== e.last) begin
          $error("out_last expected %0b actual %0b", e.last, out_last);
          fails++;
        end
      end
      g = draw_gap(out_calm);
      out_ready <= (g == 0);
      out_gap <= (g == 0) ? 0 : g - 1;
    end else if (out_gap != 0) begin
      out_ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_mode(MODE_ENCODE);

    // add with and without wrap, opcode on the final byte
    queue_byte(8'h00, 1'b0);
    queue_byte(OP_CALL, 1'b0);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h56, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(OP_JMP, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(OP_JMP, 1'b1);
    // stream ends while collecting
    queue_byte(OP_CALL, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h33, 1'b1);
    queue_byte(OP_CALL, 1'b0);
    queue_byte(8'hAA, 1'b1);
    // opcodes inside an operand, last on the fourth operand byte
    queue_byte(OP_CALL, 1'b0);
    queue_byte(OP_CALL, 1'b0);
    queue_byte(OP_JMP, 1'b0);
    queue_byte(OP_CALL, 1'b0);
    queue_byte(OP_JMP, 1'b1);
    // mode switch in the middle of an operand
    queue_byte(8'h00, 1'b0);
    queue_byte(OP_CALL, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    wait_drained();
    write_mode(MODE_DECODE);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h04, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_mode((p < 2) ? mode_t'(p[0]) : mode_t'($urandom_range(0, 1)));
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      queue_random(24);
      wait_drained();
    end

    in_calm = 1'b0;
    out_calm = 1'b0;
    queue_byte(8'($urandom_range(0, 255)), 1'b1);
    wait_drained();

    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/xcj_pkg.sv
rtl/core/xcj_front.sv
rtl/core/xcj_queue.sv
rtl/core/xcj_back.sv
rtl/core/x86_call_jump_address_filter_core.sv
verif/x86_call_jump_address_filter_core_tb.sv
